// ===== rtl/core/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants for the bitmap slot allocator
// Transaction payloads, operation codes, sequencer states and the
// lowest-zero encoder used by the free-slot scan.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // Default map size and geometry
    localparam int NUM_SLOTS_DEF = 4096;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = 6;    // bit position within a word
    localparam int INDEX_W       = 12;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;

    // Request transaction
    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] bit_index;
        logic               bit_value;
    } bsa_in_t;

    // Result transaction
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] slot_index;
        logic               bit_state;
    } bsa_out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RMW,
        ST_FIND,
        ST_HOLD
    } state_t;

    // Position of the lowest zero bit; binary halving over six levels.
    // An all-ones word yields 63.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [BIT_W-1:0]  pos;
        logic [WORD_W-1:0] low_mask;
        v   = ~w;
        pos = '0;
        for (int l = BIT_W - 1; l >= 0; l--) begin
            low_mask = (64'(1) << (1 << l)) - 64'(1);
            if ((v & low_mask) == '0) begin
                pos[l] = 1'b1;
                v      = v >> (1 << l);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/core/bitmap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator: first-fit free-slot allocator over a usage bitmap
// Write, test and find-lowest-free on a word-organized bitmap memory,
// driven by a small sequencer around a single read/compare datapath.
// ----------------------------------------------------------------------------
// Operation: write and test read the addressed word and then update it or
//   return the bit; find examines one memory word per cycle through the
//   single read port, up to the last word of the map.
// Throughput: one transaction in flight; s_ready is high only when idle.
// Reset: a clearing pass zeroes the map, one word per cycle; no request is
//   accepted meanwhile.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bsa_pkg::bsa_in_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output bsa_pkg::bsa_out_t m_payload
);

    localparam int MAP_WORDS = (NUM_SLOTS + bsa_pkg::WORD_W - 1) / bsa_pkg::WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SW        = AW + bsa_pkg::BIT_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    // Sequencer and request registers
    bsa_pkg::state_t   state_reg, state_next;
    bsa_pkg::bsa_in_t  req_reg, req_next;
    logic              req_ok_reg, req_ok_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [AW-1:0]     scan_rd_reg, scan_rd_next;
    logic              issue_more_reg, issue_more_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [AW-1:0]     chk_addr_reg, chk_addr_next;

    // Output register and pending result
    logic              m_valid_reg, m_valid_next;
    bsa_pkg::bsa_out_t m_payload_reg, m_payload_next;
    bsa_pkg::bsa_out_t pend_reg, pend_next;

    // Memory ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [bsa_pkg::WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [bsa_pkg::WORD_W-1:0]  ram_rdata;

    // Datapath helpers
    logic                        s_fire;
    logic                        out_free;
    logic                        finish;
    bsa_pkg::bsa_out_t           result;
    logic [AW-1:0]               req_word;
    logic [bsa_pkg::BIT_W-1:0]   req_bit;
    logic [bsa_pkg::WORD_W-1:0]  bit_mask;
    logic [bsa_pkg::BIT_W-1:0]   zero_pos;
    logic [SW-1:0]               slot_full;
    logic                        word_full;

    bsa_ram #(
        .WIDTH (bsa_pkg::WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == bsa_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Word address and bit position of the stored request
    assign req_word  = AW'(req_reg.bit_index >> bsa_pkg::BIT_W);
    assign req_bit   = req_reg.bit_index[bsa_pkg::BIT_W-1:0];
    assign bit_mask  = bsa_pkg::WORD_W'(1) << req_bit;

    // Scan compare: lowest free position of the word just read
    assign word_full = (ram_rdata == '1);
    assign zero_pos  = bsa_pkg::lowest_zero(ram_rdata);
    assign slot_full = {chk_addr_reg, zero_pos};

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        req_ok_next     = req_ok_reg;
        clr_addr_next   = clr_addr_reg;
        scan_rd_next    = scan_rd_reg;
        issue_more_next = issue_more_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = req_word;
        ram_wdata       = '0;
        ram_raddr       = req_word;
        finish          = 1'b0;
        result          = '0;

        case (state_reg)
            bsa_pkg::ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD) begin
                    state_next = bsa_pkg::ST_IDLE;
                end
            end
            bsa_pkg::ST_IDLE: begin
                if (s_fire) begin
                    req_next    = s_payload;
                    req_ok_next = (32'(s_payload.bit_index) < NUM_SLOTS);
                    if (s_payload.operation == bsa_pkg::OP_FIND) begin
                        state_next      = bsa_pkg::ST_FIND;
                        scan_rd_next    = '0;
                        issue_more_next = 1'b1;
                    end else if ((s_payload.operation == bsa_pkg::OP_WRITE ||
                                  s_payload.operation == bsa_pkg::OP_TEST) &&
                                 (32'(s_payload.bit_index) < NUM_SLOTS)) begin
                        state_next = bsa_pkg::ST_READ;
                    end else begin
                        // out-of-range index or unused code: zero result
                        finish = 1'b1;
                    end
                end
            end
            bsa_pkg::ST_READ: begin
                state_next = bsa_pkg::ST_RMW;
            end
            bsa_pkg::ST_RMW: begin
                finish = 1'b1;
                if (req_reg.operation == bsa_pkg::OP_WRITE) begin
                    ram_we    = 1'b1;
                    ram_wdata = (ram_rdata & ~bit_mask) |
                                (bsa_pkg::WORD_W'(req_reg.bit_value) << req_bit);
                end else begin
                    result.bit_state = ram_rdata[req_bit];
                end
            end
            bsa_pkg::ST_FIND: begin
                // issue one read per cycle
                ram_raddr = scan_rd_reg;
                if (issue_more_reg) begin
                    chk_vld_next  = 1'b1;
                    chk_addr_next = scan_rd_reg;
                    scan_rd_next  = scan_rd_reg + AW'(1);
                    if (scan_rd_reg == LAST_WORD) begin
                        issue_more_next = 1'b0;
                    end
                end
                // examine the word that came back
                if (chk_vld_reg) begin
                    if (!word_full) begin
                        finish = 1'b1;
                        if (32'(slot_full) < NUM_SLOTS) begin
                            result.found      = 1'b1;
                            result.slot_index = bsa_pkg::INDEX_W'(slot_full);
                        end
                    end else if (chk_addr_reg == LAST_WORD) begin
                        finish = 1'b1;
                    end
                end
            end
            bsa_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = bsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsa_pkg::ST_IDLE;
            end
        endcase

        if (finish) begin
            state_next = out_free ? bsa_pkg::ST_IDLE : bsa_pkg::ST_HOLD;
        end
    end

    // Output register: load a finished result or release a held one
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        pend_next      = pend_reg;
        if (finish) begin
            if (out_free) begin
                m_valid_next   = 1'b1;
                m_payload_next = result;
            end else begin
                pend_next = result;
            end
        end else if (state_reg == bsa_pkg::ST_HOLD && out_free) begin
            m_valid_next   = 1'b1;
            m_payload_next = pend_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bsa_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            issue_more_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_more_reg <= issue_more_next;
            chk_vld_reg    <= chk_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        req_ok_reg    <= req_ok_next;
        scan_rd_reg   <= scan_rd_next;
        chk_addr_reg  <= chk_addr_next;
        m_payload_reg <= m_payload_next;
        pend_reg      <= pend_next;
    end

    // Checks
    a_idle_req_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsa_pkg::ST_READ) |-> req_ok_reg)
        else $error("memory access issued for an out-of-range index");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.found) |-> (m_payload.slot_index == '0))
        else $error("slot index nonzero without a found slot");

    a_found_test_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload.found && m_payload.bit_state))
        else $error("find and test results both set");

    a_rise_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg != bsa_pkg::ST_CLEAR))
        else $error("result produced during the clearing pass");

    a_chk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_vld_reg |-> (chk_addr_reg <= LAST_WORD))
        else $error("scan examined a word beyond the map");

endmodule

// ===== rtl/core/bsa_ram.sv =====
// ----------------------------------------------------------------------------
// bsa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the bitmap slot allocator
// Drives write, test and find requests through the valid/ready request
// channel with random gaps and result back-pressure. A behavioral copy of
// the usage map predicts every result. A short directed table comes first.
// Random traffic follows, first on a sparse map, then spread over the
// whole map.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          SLOTS      = bsa_pkg::NUM_SLOTS_DEF;
    localparam int          MAP_WORDS  = (SLOTS + 63) / 64;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          WDOG_LIMIT = 4000;
    localparam int          DRAIN_WAIT = MAP_WORDS + 16;

    // Clock, reset and DUT ports
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    bsa_pkg::bsa_in_t  s_payload = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    bsa_pkg::bsa_out_t m_payload;

    // Directed stimulus table row
    typedef struct {
        bsa_pkg::bsa_in_t  req;
        bit                pinned;
        bsa_pkg::bsa_out_t want;
    } dir_row_t;

    logic [63:0]       shadow_map [MAP_WORDS];
    bsa_pkg::bsa_out_t pending_results [$];
    dir_row_t          dir_table [$];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  requests_sent = 0;
    int  finds_sent = 0;
    int  finds_on_full = 0;
    int  idle_cycles = 0;
    bit  tx_no_gaps = 1'b0;
    int  rx_stall_pct = 20;
    int  rx_stall_left = 0;

    bitmap_slot_allocator #(
        .NUM_SLOTS (SLOTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Behavioral map: applies one request and returns its result
    function automatic bsa_pkg::bsa_out_t predict_request(input bsa_pkg::bsa_in_t req);
        bsa_pkg::bsa_out_t res;
        int                idx;
        int                slot;
        res = '0;
        idx = int'(req.bit_index);
        case (req.operation)
            bsa_pkg::OP_WRITE: begin
                if (idx < SLOTS)
                    shadow_map[idx / 64][idx % 64] = req.bit_value;
            end
            bsa_pkg::OP_TEST: begin
                if (idx < SLOTS)
                    res.bit_state = shadow_map[idx / 64][idx % 64];
            end
            bsa_pkg::OP_FIND: begin
                slot = -1;
                for (int w = 0; w < MAP_WORDS && slot < 0; w++) begin
                    for (int b = 0; b < 64 && slot < 0; b++) begin
                        if (!shadow_map[w][b])
                            slot = w * 64 + b;
                    end
                end
                if (slot >= 0 && slot < SLOTS) begin
                    res.found      = 1'b1;
                    res.slot_index = slot[bsa_pkg::INDEX_W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic bsa_pkg::bsa_in_t make_req(input logic [1:0] op, input int idx,
                                                  input bit val);
        bsa_pkg::bsa_in_t req;
        req.operation = op;
        req.bit_index = idx[bsa_pkg::INDEX_W-1:0];
        req.bit_value = val;
        return req;
    endfunction

    // Mostly back-to-back or short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Re-roll idling behavior; sometimes both sides run flat out
    task automatic shuffle_idling();
        if ($urandom_range(0, 3) == 0) begin
            tx_no_gaps   = 1'b1;
            rx_stall_pct = 0;
        end else begin
            tx_no_gaps   = $urandom_range(0, 4) == 0;
            rx_stall_pct = $urandom_range(0, 60);
        end
    endtask

    // Send one request transaction; expected result is queued at acceptance
    task automatic send_request(input bsa_pkg::bsa_in_t req, input bit pinned,
                                input bsa_pkg::bsa_out_t want,
                                output bsa_pkg::bsa_out_t res);
        int gap;
        s_payload <= req;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        res = predict_request(req);
        if (req.operation == bsa_pkg::OP_FIND) begin
            finds_sent++;
            if (!res.found)
                finds_on_full++;
        end
        pending_results.push_back(pinned ? want : res);
        requests_sent++;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic add_row(input logic [1:0] op, input int idx, input bit val,
                           input bit pinned, input bit f, input int slot, input bit st);
        dir_row_t row;
        row.req             = make_req(op, idx, val);
        row.pinned          = pinned;
        row.want.found      = f;
        row.want.slot_index = slot[bsa_pkg::INDEX_W-1:0];
        row.want.bit_state  = st;
        dir_table.push_back(row);
    endtask

    // Random traffic; whole_map spreads indexes over the whole map
    task automatic run_mix(input int count, input bit whole_map);
        bsa_pkg::bsa_out_t res;
        int                r;
        int                idx;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                shuffle_idling();
            r   = $urandom_range(0, 99);
            idx = (whole_map || $urandom_range(0, 3) == 0) ?
                  $urandom_range(0, SLOTS - 1) : $urandom_range(0, 320);
            if (r < 35) begin
                // Allocate: find the lowest free slot, then claim it
                send_request(make_req(bsa_pkg::OP_FIND, $urandom, 1'($urandom)),
                             1'b0, '0, res);
                if (res.found)
                    send_request(make_req(bsa_pkg::OP_WRITE, int'(res.slot_index), 1'b1),
                                 1'b0, '0, res);
            end else if (r < 58) begin
                send_request(make_req(bsa_pkg::OP_WRITE, idx, 1'b0), 1'b0, '0, res);
            end else if (r < 78) begin
                send_request(make_req(bsa_pkg::OP_TEST, idx, 1'($urandom)), 1'b0, '0, res);
            end else if (r < 88) begin
                send_request(make_req(bsa_pkg::OP_WRITE, idx, 1'($urandom)), 1'b0, '0, res);
            end else if (r < 95) begin
                send_request(make_req(bsa_pkg::OP_FIND, $urandom, 1'($urandom)),
                             1'b0, '0, res);
            end else begin
                send_request(make_req(OP_UNUSED, $urandom, 1'($urandom)), 1'b0, '0, res);
            end
        end
    endtask

    // Result back-pressure: random stalls of random length
    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_ready       <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct)
                rx_stall_left <= ($urandom_range(0, 9) == 0) ?
                                 $urandom_range(10, 40) : $urandom_range(1, 3);
        end
    end

    // Result checker: compare each transaction with the oldest expectation
    always @(posedge aclk) begin
        bsa_pkg::bsa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", m_payload));
            end else begin
                want = pending_results.pop_front();
                if (m_payload.found !== want.found)
                    report_mismatch($sformatf("result %0d found: expected %0d, got %0d",
                                    results_checked, want.found, m_payload.found));
                if (m_payload.slot_index !== want.slot_index)
                    report_mismatch($sformatf("result %0d slot_index: expected %0d, got %0d",
                                    results_checked, want.slot_index,
                                    m_payload.slot_index));
                if (m_payload.bit_state !== want.bit_state)
                    report_mismatch($sformatf("result %0d bit_state: expected %0d, got %0d",
                                    results_checked, want.bit_state, m_payload.bit_state));
            end
            results_checked++;
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Main sequence
    initial begin
        bsa_pkg::bsa_out_t res;

        for (int w = 0; w < MAP_WORDS; w++)
            shadow_map[w] = '0;

        // Directed table: reset state, extremes, unused code, word edges
        add_row(bsa_pkg::OP_FIND,  0,    0, 1, 1, 0, 0);
        add_row(bsa_pkg::OP_TEST,  0,    0, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_TEST,  4095, 1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_WRITE, 0,    1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_TEST,  0,    0, 1, 0, 0, 1);
        add_row(bsa_pkg::OP_FIND,  0,    0, 1, 1, 1, 0);
        add_row(bsa_pkg::OP_WRITE, 4095, 1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_TEST,  4095, 0, 1, 0, 0, 1);
        add_row(bsa_pkg::OP_FIND,  0,    0, 1, 1, 1, 0);
        add_row(bsa_pkg::OP_WRITE, 1,    1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_WRITE, 2,    1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_FIND,  0,    0, 0, 0, 0, 0);
        add_row(OP_UNUSED,         4095, 1, 1, 0, 0, 0);
        add_row(OP_UNUSED,         0,    0, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_TEST,  4095, 0, 1, 0, 0, 1);
        add_row(bsa_pkg::OP_WRITE, 0,    0, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_FIND,  0,    0, 1, 1, 0, 0);
        add_row(bsa_pkg::OP_WRITE, 63,   1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_WRITE, 64,   1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_TEST,  64,   0, 1, 0, 0, 1);
        add_row(bsa_pkg::OP_TEST,  65,   1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_WRITE, 4095, 0, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_TEST,  4095, 1, 1, 0, 0, 0);
        add_row(bsa_pkg::OP_FIND,  4095, 1, 1, 1, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i])
            send_request(dir_table[i].req, dir_table[i].pinned, dir_table[i].want, res);

        // Sparse map: allocations build up from the bottom
        run_mix(110, 1'b0);

        // Frees, claims and tests scattered across all words
        run_mix(250, 1'b1);

        // Drain
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d requests, %0d results checked; %0d finds, %0d on a full map.",
                 requests_sent, results_checked, finds_sent, finds_on_full);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== bitmap_slot_allocator.f =====
rtl/core/bsa_pkg.sv
rtl/core/bsa_ram.sv
rtl/core/bitmap_slot_allocator.sv
test/tb_top.sv
